// ===== sv/hash_message_padder_core_macros.svh =====
// Assertion macros for the hash message padder.
`ifndef HASH_MESSAGE_PADDER_CORE_MACROS_SVH
`define HASH_MESSAGE_PADDER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define HMP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hmp assertion failed");
`define HMP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hmp assertion failed");
`else
`define HMP_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define HMP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== sv/hmp_pkg.sv =====
// Shared types and constants for the hash message padder.
package hmp_pkg;

  localparam int unsigned WORD_W    = 64;
  localparam int unsigned POS_W     = 7;
  localparam logic [7:0]  PAD_MARK  = 8'h80;

  localparam logic REG_BLOCK_SIZE = 1'b0;
  localparam logic REG_LEN_LE     = 1'b1;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_DATA,
    OP_MARK,
    OP_ZWORD,
    OP_LEN
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic slot_free;
    logic pad_done;
  } status_t;

endpackage

// ===== sv/hmp_datapath.sv =====
// Padder datapath: word gather, block position, byte count and output register.
module hmp_datapath #(
  parameter int unsigned BYTE_COUNT_WIDTH = 61
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  hmp_pkg::cmd_t               cmd,
  input  logic [7:0]                  in_byte,
  input  logic                        in_present,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic                        cfg_wdata,
  input  logic                        out_tready,
  output hmp_pkg::status_t            status,
  output logic                        out_tvalid,
  output logic [hmp_pkg::WORD_W-1:0]  out_tdata,
  output logic                        out_tuser,
  output logic                        out_tlast
);

  logic                        blk_sel_r;
  logic                        len_le_r;
  logic [hmp_pkg::WORD_W-1:0]  word_r, word_nxt;
  logic [hmp_pkg::POS_W-1:0]   pos_r, pos_nxt;
  logic [BYTE_COUNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic                        out_valid_r;
  logic [hmp_pkg::WORD_W-1:0]  out_word_r;
  logic                        out_blast_r;
  logic                        out_mlast_r;

  logic [hmp_pkg::POS_W-1:0]   mask;
  logic [hmp_pkg::POS_W-1:0]   pos_eff;
  logic [2:0]                  lane;
  logic [7:0]                  byte_val;
  logic [hmp_pkg::WORD_W-1:0]  placed;
  logic [hmp_pkg::POS_W-1:0]   pos_inc;
  logic [hmp_pkg::POS_W-1:0]   pos_zw;
  logic [hmp_pkg::WORD_W-1:0]  bit_len;
  logic [hmp_pkg::WORD_W-1:0]  len_word;
  logic                        slot_free;
  logic                        emit;
  logic [hmp_pkg::WORD_W-1:0]  e_word;
  logic                        e_blast;
  logic                        e_mlast;

  function automatic logic [63:0] byte_swap(input logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 8; i++) begin
      r[8*i +: 8] = v[8*(7-i) +: 8];
    end
    return r;
  endfunction

  assign mask     = blk_sel_r ? 7'h7F : 7'h3F;
  assign pos_eff  = pos_r & mask;
  assign lane     = pos_eff[2:0];
  assign byte_val = (cmd.op == hmp_pkg::OP_MARK) ? hmp_pkg::PAD_MARK : in_byte;
  assign placed   = {byte_val, 56'd0} >> {lane, 3'b000};
  assign pos_inc  = (pos_eff + 7'd1) & mask;
  assign pos_zw   = ({pos_eff[6:3], 3'b000} + 7'd8) & mask;
  assign bit_len  = 64'({cnt_r, 3'b000});
  assign len_word = len_le_r ? byte_swap(bit_len) : bit_len;
  assign slot_free = !out_valid_r || out_tready;

  assign status.slot_free = slot_free;
  assign status.pad_done  = (pos_eff == (mask - 7'd7));

  always_comb begin
    word_nxt = word_r;
    pos_nxt  = pos_r;
    cnt_nxt  = cnt_r;
    emit     = 1'b0;
    e_word   = word_r;
    e_blast  = 1'b0;
    e_mlast  = 1'b0;
    unique case (cmd.op)
      hmp_pkg::OP_NOP: begin
      end
      hmp_pkg::OP_DATA, hmp_pkg::OP_MARK: begin
        if (cmd.op == hmp_pkg::OP_MARK || in_present) begin
          pos_nxt = pos_inc;
          if (lane == 3'd7) begin
            emit     = 1'b1;
            e_word   = word_r | placed;
            e_blast  = (pos_inc == '0);
            word_nxt = '0;
          end else begin
            word_nxt = word_r | placed;
          end
          if (cmd.op == hmp_pkg::OP_DATA) begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      hmp_pkg::OP_ZWORD: begin
        emit     = 1'b1;
        e_word   = word_r;
        e_blast  = (pos_zw == '0);
        pos_nxt  = pos_zw;
        word_nxt = '0;
      end
      hmp_pkg::OP_LEN: begin
        emit     = 1'b1;
        e_word   = len_word;
        e_blast  = 1'b1;
        e_mlast  = 1'b1;
        pos_nxt  = '0;
        word_nxt = '0;
        cnt_nxt  = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_sel_r   <= 1'b0;
      len_le_r    <= 1'b0;
      word_r      <= '0;
      pos_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          hmp_pkg::REG_BLOCK_SIZE: blk_sel_r <= cfg_wdata;
          hmp_pkg::REG_LEN_LE:     len_le_r  <= cfg_wdata;
          default: begin
          end
        endcase
      end
      word_r <= word_nxt;
      pos_r  <= pos_nxt;
      cnt_r  <= cnt_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_word_r  <= e_word;
      out_blast_r <= e_blast;
      out_mlast_r <= e_mlast;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_word_r;
  assign out_tuser  = out_blast_r;
  assign out_tlast  = out_mlast_r;

endmodule

// ===== sv/hmp_ctrl.sv =====
// Padder controller: byte intake, end marker, zero fill and length sequencing.
module hmp_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_tlast,
  input  hmp_pkg::status_t status,
  output logic             in_tready,
  output hmp_pkg::cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MARK,
    S_PAD
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    cmd.op    = hmp_pkg::OP_NOP;
    unique case (state_r)
      S_IDLE: begin
        in_tready = status.slot_free;
        if (in_tvalid && status.slot_free) begin
          cmd.op = hmp_pkg::OP_DATA;
          if (in_tlast) begin
            state_nxt = S_MARK;
          end
        end
      end
      S_MARK: begin
        if (status.slot_free) begin
          cmd.op    = hmp_pkg::OP_MARK;
          state_nxt = S_PAD;
        end
      end
      S_PAD: begin
        if (status.slot_free) begin
          if (status.pad_done) begin
            cmd.op    = hmp_pkg::OP_LEN;
            state_nxt = S_IDLE;
          end else begin
            cmd.op = hmp_pkg::OP_ZWORD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== sv/hash_message_padder_core.sv =====
// Top level of the hash message padder: controller, datapath and checks.
//
// Input channel in_*: one message byte per beat. in_tdata[7:0] holds the
// byte, in_tuser says the byte is present, in_tlast ends the message.
// Output channel out_*: one 64-bit padded word per beat, first stream byte
// in bits 63..56; out_tuser marks the end of a block, out_tlast the final
// word of the message.
// Config: cfg_we with cfg_index 0 selects 128-byte blocks (cfg_wdata=1) or
// 64-byte blocks; index 1 selects a little-endian length field.
// Throughput: beats without end of message are taken back to back while the
// output slot is free. An end beat adds the end marker and 1 to 17 zero fill
// and length words, one per free cycle of the single output register.
// Latency: a word appears on out_* the cycle after the beat that finishes it.
// When the receiver stalls, the output register holds its word and the
// controller waits; in_tready stays low until the slot frees.
// Reset (synchronous, rst_n low) clears the position, the byte count, the
// partial word, the config registers and the output valid flag.
`include "hash_message_padder_core_macros.svh"

module hash_message_padder_core #(
  parameter int unsigned BYTE_COUNT_WIDTH = 61
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] byte_present
  input  logic        in_tlast,   // message_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [63:0] padded_word
  output logic        out_tuser,  // [0] block_last
  output logic        out_tlast,  // message_last
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic        cfg_wdata
);

  hmp_pkg::cmd_t    cmd;
  hmp_pkg::status_t status;

  hmp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .status    (status),
    .in_tready (in_tready),
    .cmd       (cmd)
  );

  hmp_datapath #(
    .BYTE_COUNT_WIDTH (BYTE_COUNT_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_byte    (in_tdata),
    .in_present (in_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .out_tready (out_tready),
    .status     (status),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  `HMP_ASSERT_NOW(a_ready_needs_slot, clk, rst_n, in_tready, !out_tvalid || out_tready)
  `HMP_ASSERT_NOW(a_msg_end_is_block_end, clk, rst_n, out_tvalid && out_tlast, out_tuser)
  `HMP_ASSERT_NEXT(a_end_beat_blocks_input, clk, rst_n, in_tvalid && in_tready && in_tlast,
                   !in_tready)

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the hash message padder: random byte streams, padded word check.
module tb_top;

  localparam int CNT_W      = 61;
  localparam int LIMIT      = 300000;
  localparam int SETTLE     = 40;
  localparam int HOLD_LEN   = 400;
  localparam int RAND_ITEMS = 500;

  typedef struct {
    logic [7:0] data;
    logic       present;
    logic       eom;
  } msg_beat_t;

  typedef struct {
    logic [hmp_pkg::WORD_W-1:0] word;
    logic                       blk_end;
    logic                       msg_end;
  } pad_word_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'd0;
  logic        in_tuser   = 1'b0;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  logic        cfg_we     = 1'b0;
  logic        cfg_index  = 1'b0;
  logic        cfg_wdata  = 1'b0;

  msg_beat_t beat_q[$];
  pad_word_t exp_words[$];

  // padder state as predicted
  logic                       blk128;
  logic                       len_le;
  logic [hmp_pkg::WORD_W-1:0] gather_word;
  logic [hmp_pkg::POS_W-1:0]  blk_pos;
  logic [CNT_W-1:0]           msg_bytes;
  int                         step_words;

  bit no_idle  = 1'b0;
  bit hold_go  = 1'b0;
  bit hold_off = 1'b0;
  int mismatches = 0;
  int cycles = 0;
  int items_added = 0;

  hash_message_padder_core #(.BYTE_COUNT_WIDTH(CNT_W)) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic [hmp_pkg::POS_W-1:0] size_mask();
    return blk128 ? 7'h7F : 7'h3F;
  endfunction

  task automatic place_byte(input logic [7:0] b, input logic is_final);
    logic [hmp_pkg::POS_W-1:0] pos;
    logic [2:0]                lane;
    pad_word_t                 w;
    pos  = blk_pos & size_mask();
    lane = pos[2:0];
    gather_word = gather_word | ({56'd0, b} << (56 - 8 * lane));
    pos  = (pos + 7'd1) & size_mask();
    blk_pos = pos;
    if (lane == 3'd7) begin
      if (step_words < 18) begin
        w.word    = gather_word;
        w.blk_end = (pos == '0);
        w.msg_end = is_final;
        exp_words.push_back(w);
        step_words++;
      end
      gather_word = '0;
    end
  endtask

  task automatic pad_beat(input logic [7:0] data, input logic present, input logic eom);
    logic [63:0] bit_len;
    step_words = 0;
    if (present) begin
      place_byte(data, 1'b0);
      msg_bytes = msg_bytes + 1'b1;
    end
    if (eom) begin
      bit_len = 64'(msg_bytes) << 3;
      place_byte(hmp_pkg::PAD_MARK, 1'b0);
      while ((blk_pos & size_mask()) != size_mask() - 7'd7)
        place_byte(8'h00, 1'b0);
      for (int i = 0; i < 8; i++)
        place_byte(8'(bit_len >> (len_le ? 8 * i : 8 * (7 - i))), i == 7);
      gather_word = '0;
      blk_pos     = '0;
      msg_bytes   = '0;
    end
  endtask

  task automatic report_mismatch(input string what, input pad_word_t e, input pad_word_t a);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch (%s): exp word %h blk %b msg %b, got word %h blk %b msg %b",
               what, e.word, e.blk_end, e.msg_end, a.word, a.blk_end, a.msg_end);
  endtask

  task automatic push_beat(input logic [7:0] d, input logic p, input logic e);
    msg_beat_t b;
    b.data    = d;
    b.present = p;
    b.eom     = e;
    beat_q.push_back(b);
    if (p || e)
      items_added++;
  endtask

  task automatic add_msg(input int len, input bit close, input bit end_on_byte);
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 7) == 0)
        push_beat(8'($urandom), 1'b0, 1'b0);
      push_beat(8'($urandom), 1'b1, close && end_on_byte && (k == len - 1));
    end
    if (close && !(end_on_byte && len > 0))
      push_beat(8'($urandom), 1'b0, 1'b1);
  endtask

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70)
      return $urandom_range(0, 24);
    else if (r < 90)
      return $urandom_range(50, 70);
    else
      return $urandom_range(71, 140);
  endfunction

  task automatic write_reg(input logic idx, input logic val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == hmp_pkg::REG_BLOCK_SIZE)
      blk128 = val;
    else
      len_le = val;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (beat_q.size() != 0 || in_tvalid || exp_words.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic gen_phase(input int target);
    int start;
    start = items_added;
    @(negedge clk);
    while (items_added - start < target) begin
      if ($urandom_range(0, 9) == 0) begin
        push_beat(8'($urandom), 1'b0, 1'b1);
        push_beat(8'($urandom), 1'b0, 1'b1);
      end else begin
        add_msg(pick_len(), 1'b1, $urandom_range(0, 1));
      end
    end
    // leave a message open so the next settings land mid-message
    if ($urandom_range(0, 9) < 4)
      add_msg($urandom_range(0, 1) ? $urandom_range(1, 20) : $urandom_range(65, 90), 1'b0, 1'b0);
  endtask

  // driver
  always @(posedge clk) begin : drv
    msg_beat_t b;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (beat_q.size() != 0 && (no_idle || $urandom_range(0, 99) >= 22)) begin
        b = beat_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= b.data;
        in_tuser  <= b.present;
        in_tlast  <= b.eom;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (!rst_n || hold_off)
      out_tready <= 1'b0;
    else
      out_tready <= no_idle || ($urandom_range(0, 99) >= 22);
  end

  initial begin
    wait (hold_go);
    repeat (30) @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_LEN) @(posedge clk);
    hold_off <= 1'b0;
  end

  // monitor: predict on input beats, check output beats
  always @(posedge clk) begin : mon
    pad_word_t e;
    pad_word_t a;
    if (rst_n) begin
      if (in_tvalid && in_tready)
        pad_beat(in_tdata, in_tuser, in_tlast);
      if (out_tvalid && out_tready) begin
        a.word    = out_tdata;
        a.blk_end = out_tuser;
        a.msg_end = out_tlast;
        if (exp_words.size() == 0) begin
          e = '{default: '0};
          report_mismatch("unexpected beat", e, a);
        end else begin
          e = exp_words.pop_front();
          if (a.word !== e.word || a.blk_end !== e.blk_end || a.msg_end !== e.msg_end)
            report_mismatch("field", e, a);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int rand_start;
    int ph;
    blk128      = 1'b0;
    len_le      = 1'b0;
    gather_word = '0;
    blk_pos     = '0;
    msg_bytes   = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed
    write_reg(hmp_pkg::REG_BLOCK_SIZE, 1'b0);
    write_reg(hmp_pkg::REG_LEN_LE, 1'b0);
    @(negedge clk);
    push_beat(8'h5A, 1'b0, 1'b1);                 // empty message
    push_beat(8'hA5, 1'b0, 1'b0);                 // nothing at all
    push_beat(8'hFF, 1'b1, 1'b1);                 // byte and end together
    push_beat(8'h00, 1'b1, 1'b0);
    for (int k = 1; k < 7; k++)
      push_beat(8'(k), 1'b1, 1'b0);
    push_beat(8'h80, 1'b1, 1'b0);
    push_beat(8'h3C, 1'b0, 1'b1);                 // end with no byte on a word edge
    wait_idle();
    write_reg(hmp_pkg::REG_BLOCK_SIZE, 1'b1);
    write_reg(hmp_pkg::REG_LEN_LE, 1'b1);
    @(negedge clk);
    push_beat(8'h00, 1'b0, 1'b1);
    push_beat(8'hFF, 1'b1, 1'b0);
    push_beat(8'h7F, 1'b1, 1'b0);
    push_beat(8'hFE, 1'b1, 1'b1);
    push_beat(8'h01, 1'b1, 1'b0);
    push_beat(8'hC3, 1'b0, 1'b1);
    wait_idle();

    // random phases
    rand_start = items_added;
    ph = 0;
    while (items_added - rand_start < RAND_ITEMS) begin
      if (ph < 4) begin
        write_reg(hmp_pkg::REG_BLOCK_SIZE, ph[0]);
        write_reg(hmp_pkg::REG_LEN_LE, ph[1]);
      end else begin
        write_reg(hmp_pkg::REG_BLOCK_SIZE, 1'($urandom_range(0, 1)));
        write_reg(hmp_pkg::REG_LEN_LE, 1'($urandom_range(0, 1)));
      end
      gen_phase($urandom_range(60, 100));
      no_idle = (ph == 2);
      if (ph == 0)
        hold_go = 1'b1;
      wait_idle();
      no_idle = 1'b0;
      ph++;
    end
    // close any open message
    @(negedge clk);
    push_beat(8'h00, 1'b0, 1'b1);

    @(negedge clk);
    while (beat_q.size() != 0 || in_tvalid)
      @(negedge clk);
    while (exp_words.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (mismatches == 0 && exp_words.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
